@@ rtl/assert_macros.svh @@
// Assertion macros for the modules that check themselves.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/ccs_pkg.sv @@
package ccs_pkg;

    localparam int IMAGE_WIDTH  = 64;
    localparam int IMAGE_HEIGHT = 64;
    localparam int MAX_LABELS   = 64;

    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
    localparam int LBL_W  = $clog2(MAX_LABELS + 1);
    localparam int PIX_W  = 8;
    localparam int INT_W  = 20;
    localparam int WSUM_W = 26;
    localparam int CEN_W  = 6;

    // Queue between the front and back parts; the depth is a power of two.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd70;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             lit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_pix;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [INT_W-1:0]  isum;
        logic [WSUM_W-1:0] rsum;
        logic [WSUM_W-1:0] csum;
    } sums_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABOVE,
        S_FIND_A,
        S_FIND_L,
        S_ADD,
        S_DONE,
        S_FOLD_RD,
        S_FOLD_CHK,
        S_FOLD_FIND,
        S_FOLD_SI,
        S_FOLD_SR,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_DIV,
        S_EMPTY,
        S_CLEAR
    } back_state_t;

endpackage

@@ rtl/ccl_star_centroid.sv @@
// Pixel work in the labelling engine: background or a new label passes S_IDLE, S_ABOVE and
// S_DONE; extending one adds S_ADD, and a join first walks the parent table to each root.
// After the last pixel each label is tested as a root and merged labels' sums are folded into
// its root, then each star passes the 26-step shared divider before its result registers.
// Reset (rst_n, asynchronous, active low) gives threshold 70 and an empty frame; the label
// tables need no clearing pass since only labels created in the current frame are read.
`include "assert_macros.svh"

module ccl_star_centroid
    import ccs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PIX_W-1:0] pixel,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             threshold_we,
    input  logic [PIX_W-1:0] threshold,
    output logic             star_valid,
    output logic [CEN_W-1:0] row_centroid,
    output logic [CEN_W-1:0] col_centroid,
    output logic             last_of_frame,
    output logic             label_overflow,
    output logic             out_valid,
    input  logic             out_ready
);

    // The front part counts raster position and binarises each pixel as it is
    // transferred in, so the camera side never waits on the labelling engine
    // until the queue has filled.
    logic    q_push;
    logic    q_pop;
    item_t   q_in;
    item_t   q_head;
    q_stat_t q_stat;

    ccs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .threshold_we (threshold_we),
        .threshold    (threshold),
        .q_stat       (q_stat),
        .push         (q_push),
        .push_item    (q_in)
    );

    // A short queue decouples the pixel stream from the variable time taken by
    // root finding in the back part.
    ccs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    // The back part labels pixels against the union-find table, folds merged
    // labels into their roots at the end of the frame and emits one centroid
    // per root through its output register, or one empty result for a frame without labels.
    ccs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_stat         (q_stat),
        .pop            (q_pop),
        .star_valid     (star_valid),
        .row_centroid   (row_centroid),
        .col_centroid   (col_centroid),
        .last_of_frame  (last_of_frame),
        .label_overflow (label_overflow),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    // A result without a centroid only ever reports an empty frame, which is
    // always the closing result.
    `ASSERT_IMPLY(a_empty_is_last, out_valid && !star_valid, last_of_frame)

    // After the closing result of a frame the engine clears down, so nothing
    // further can be offered in the following cycle.
    `ASSERT_NEXT(a_quiet_after_last, out_valid && out_ready && last_of_frame, !out_valid)

    // A pixel transferred in must land in the queue.
    `ASSERT_NEXT(a_push_lands, in_valid && in_ready, !q_stat.empty)

endmodule

@@ rtl/ccs_front.sv @@
module ccs_front
    import ccs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PIX_W-1:0] pixel,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             threshold_we,
    input  logic [PIX_W-1:0] threshold,
    input  q_stat_t          q_stat,
    output logic             push,
    output item_t            push_item
);

    logic [PIX_W-1:0] threshold_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_col;
    logic             last_row;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;
    assign last_col = (col_reg == COL_W'(IMAGE_WIDTH - 1));
    assign last_row = (row_reg == ROW_W'(IMAGE_HEIGHT - 1));

    always_comb
    begin
        push_item.pixel    = pixel;
        push_item.lit      = (pixel >= threshold_reg);
        push_item.row      = row_reg;
        push_item.col      = col_reg;
        push_item.last_col = last_col;
        push_item.last_pix = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (threshold_we)
            begin
                threshold_reg <= threshold;
            end
            if (push)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : ROW_W'(row_reg + 1'b1);
                end
                else
                begin
                    col_reg <= COL_W'(col_reg + 1'b1);
                end
            end
        end
    end

endmodule

@@ rtl/ccs_queue.sv @@
module ccs_queue
    import ccs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t q_stat
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                cnt_reg <= (QPTR_W+1)'(cnt_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= (QPTR_W+1)'(cnt_reg - 1'b1);
            end
        end
    end

endmodule

@@ rtl/ccs_div.sv @@
module ccs_div
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WSUM_W-1:0] dividend_row,
    input  logic [WSUM_W-1:0] dividend_col,
    input  logic [INT_W-1:0]  divisor,
    output logic              busy,
    output logic [CEN_W-1:0]  quot_row,
    output logic [CEN_W-1:0]  quot_col
);

    localparam int CNT_W = $clog2(WSUM_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WSUM_W-1:0] qr_reg;
    logic [WSUM_W-1:0] qc_reg;
    logic [INT_W-1:0]  rr_reg;
    logic [INT_W-1:0]  rc_reg;
    logic [INT_W-1:0]  d_reg;
    logic [INT_W:0]    rr_sh;
    logic [INT_W:0]    rc_sh;
    logic              ge_r;
    logic              ge_c;
    logic [INT_W-1:0]  rr_next;
    logic [INT_W-1:0]  rc_next;

    // One restoring step per cycle for both quotients, sharing the divisor.
    always_comb
    begin
        rr_sh   = {rr_reg, qr_reg[WSUM_W-1]};
        rc_sh   = {rc_reg, qc_reg[WSUM_W-1]};
        ge_r    = (rr_sh >= {1'b0, d_reg});
        ge_c    = (rc_sh >= {1'b0, d_reg});
        rr_next = ge_r ? INT_W'(rr_sh - {1'b0, d_reg}) : rr_sh[INT_W-1:0];
        rc_next = ge_c ? INT_W'(rc_sh - {1'b0, d_reg}) : rc_sh[INT_W-1:0];
    end

    assign busy     = busy_reg;
    assign quot_row = (d_reg == '0) ? '0 : qr_reg[CEN_W-1:0];
    assign quot_col = (d_reg == '0) ? '0 : qc_reg[CEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(WSUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qr_reg <= dividend_row;
            qc_reg <= dividend_col;
            rr_reg <= '0;
            rc_reg <= '0;
            d_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            qr_reg <= {qr_reg[WSUM_W-2:0], ge_r};
            qc_reg <= {qc_reg[WSUM_W-2:0], ge_c};
            rr_reg <= rr_next;
            rc_reg <= rc_next;
        end
    end

endmodule

@@ rtl/ccs_back.sv @@
module ccs_back
    import ccs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            head,
    input  q_stat_t          q_stat,
    output logic             pop,
    output logic             star_valid,
    output logic [CEN_W-1:0] row_centroid,
    output logic [CEN_W-1:0] col_centroid,
    output logic             last_of_frame,
    output logic             label_overflow,
    output logic             out_valid,
    input  logic             out_ready
);

    back_state_t      state_reg, state_next;
    item_t            item_reg, item_next;
    logic [LBL_W-1:0] lab_reg, lab_next;
    logic [LBL_W-1:0] cur_reg, cur_next;
    logic [LBL_W-1:0] ra_reg, ra_next;
    logic [LBL_W-1:0] nb_reg, nb_next;
    logic [LBL_W-1:0] left_reg, left_next;
    logic [LBL_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [LBL_W-1:0] idx_reg, idx_next;
    logic [LBL_W-1:0] root_reg, root_next;
    logic [LBL_W-1:0] last_root_reg, last_root_next;
    sums_t            isum_reg, isum_next;

    logic             out_valid_reg;
    logic             star_valid_reg;
    logic [CEN_W-1:0] row_centroid_reg;
    logic [CEN_W-1:0] col_centroid_reg;
    logic             last_of_frame_reg;
    logic             label_overflow_reg;
    logic             out_load;
    logic             out_star;
    logic             out_last;

    // Label of each column in the row above, with a valid bit per column.
    logic [LBL_W-1:0]       prev_mem [IMAGE_WIDTH];
    logic [IMAGE_WIDTH-1:0] prev_vld_reg;
    logic                   prev_vq_reg;
    logic [LBL_W-1:0]       prev_q;
    logic                   prev_re, prev_we, prev_clr;
    logic [COL_W-1:0]       prev_raddr, prev_waddr;
    logic [LBL_W-1:0]       prev_wdata;

    logic [LBL_W-1:0] par_mem [MAX_LABELS + 1];
    logic [LBL_W-1:0] par_q;
    logic             par_re, par_we;
    logic [LBL_W-1:0] par_raddr, par_waddr, par_wdata;

    sums_t            sum_mem [MAX_LABELS + 1];
    sums_t            sum_q;
    logic             sum_re, sum_we;
    logic [LBL_W-1:0] sum_raddr, sum_waddr;
    sums_t            sum_wdata;

    logic                   div_start;
    logic                   div_busy;
    logic [CEN_W-1:0]       quot_row, quot_col;

    logic [LBL_W-1:0]       above, left;
    logic [ROW_W+PIX_W-1:0] rprod;
    logic [COL_W+PIX_W-1:0] cprod;
    sums_t                  init_sums, add_sums, fold_sums;
    logic                   out_free;

    assign above    = prev_vq_reg ? prev_q : '0;
    assign left     = (item_reg.col == '0) ? '0 : left_reg;
    assign rprod    = item_reg.row * item_reg.pixel;
    assign cprod    = item_reg.col * item_reg.pixel;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        init_sums.isum = INT_W'(item_reg.pixel);
        init_sums.rsum = WSUM_W'(rprod);
        init_sums.csum = WSUM_W'(cprod);
        add_sums.isum  = INT_W'(sum_q.isum + INT_W'(item_reg.pixel));
        add_sums.rsum  = WSUM_W'(sum_q.rsum + WSUM_W'(rprod));
        add_sums.csum  = WSUM_W'(sum_q.csum + WSUM_W'(cprod));
        fold_sums.isum = INT_W'(sum_q.isum + isum_reg.isum);
        fold_sums.rsum = WSUM_W'(sum_q.rsum + isum_reg.rsum);
        fold_sums.csum = WSUM_W'(sum_q.csum + isum_reg.csum);
    end

    ccs_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_row (sum_q.rsum),
        .dividend_col (sum_q.csum),
        .divisor      (sum_q.isum),
        .busy         (div_busy),
        .quot_row     (quot_row),
        .quot_col     (quot_col)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        lab_next       = lab_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        nb_next        = nb_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        root_next      = root_reg;
        last_root_next = last_root_reg;
        isum_next      = isum_reg;
        pop            = 1'b0;
        prev_re        = 1'b0;
        prev_we        = 1'b0;
        prev_clr       = 1'b0;
        prev_raddr     = head.col;
        prev_waddr     = item_reg.col;
        prev_wdata     = lab_reg;
        par_re         = 1'b0;
        par_we         = 1'b0;
        par_raddr      = idx_reg;
        par_waddr      = idx_reg;
        par_wdata      = idx_reg;
        sum_re         = 1'b0;
        sum_we         = 1'b0;
        sum_raddr      = idx_reg;
        sum_waddr      = lab_reg;
        sum_wdata      = add_sums;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_star       = 1'b1;
        out_last       = (idx_reg == last_root_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    prev_re    = 1'b1;
                    state_next = S_ABOVE;
                end
            end
            S_ABOVE:
            begin
                if (!item_reg.lit)
                begin
                    lab_next   = '0;
                    state_next = S_DONE;
                end
                else if (above == '0 && left == '0)
                begin
                    if (count_reg < LBL_W'(MAX_LABELS))
                    begin
                        count_next = LBL_W'(count_reg + 1'b1);
                        lab_next   = LBL_W'(count_reg + 1'b1);
                        par_we     = 1'b1;
                        par_waddr  = LBL_W'(count_reg + 1'b1);
                        par_wdata  = LBL_W'(count_reg + 1'b1);
                        sum_we     = 1'b1;
                        sum_waddr  = LBL_W'(count_reg + 1'b1);
                        sum_wdata  = init_sums;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        lab_next = '0;
                    end
                    state_next = S_DONE;
                end
                else if (above != '0 && left != '0)
                begin
                    lab_next   = (above < left) ? above : left;
                    nb_next    = left;
                    cur_next   = above;
                    par_re     = 1'b1;
                    par_raddr  = above;
                    state_next = S_FIND_A;
                end
                else
                begin
                    lab_next   = (above != '0) ? above : left;
                    sum_re     = 1'b1;
                    sum_raddr  = (above != '0) ? above : left;
                    state_next = S_ADD;
                end
            end
            S_FIND_A:
            begin
                par_re = 1'b1;
                if (par_q == cur_reg)
                begin
                    ra_next    = cur_reg;
                    cur_next   = nb_reg;
                    par_raddr  = nb_reg;
                    state_next = S_FIND_L;
                end
                else
                begin
                    cur_next  = par_q;
                    par_raddr = par_q;
                end
            end
            S_FIND_L:
            begin
                if (par_q == cur_reg)
                begin
                    if (cur_reg != ra_reg)
                    begin
                        par_we    = 1'b1;
                        par_waddr = (ra_reg > cur_reg) ? ra_reg : cur_reg;
                        par_wdata = (ra_reg > cur_reg) ? cur_reg : ra_reg;
                    end
                    sum_re     = 1'b1;
                    sum_raddr  = lab_reg;
                    state_next = S_ADD;
                end
                else
                begin
                    cur_next  = par_q;
                    par_re    = 1'b1;
                    par_raddr = par_q;
                end
            end
            S_ADD:
            begin
                sum_we     = 1'b1;
                sum_waddr  = lab_reg;
                sum_wdata  = add_sums;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                prev_we   = 1'b1;
                left_next = item_reg.last_col ? '0 : lab_reg;
                if (item_reg.last_pix)
                begin
                    idx_next       = LBL_W'(1);
                    last_root_next = '0;
                    state_next     = (count_reg == '0) ? S_EMPTY : S_FOLD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FOLD_RD:
            begin
                par_re     = 1'b1;
                state_next = S_FOLD_CHK;
            end
            S_FOLD_CHK:
            begin
                if (par_q == idx_reg)
                begin
                    last_root_next = idx_reg;
                    if (idx_reg == count_reg)
                    begin
                        idx_next   = LBL_W'(1);
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        idx_next   = LBL_W'(idx_reg + 1'b1);
                        state_next = S_FOLD_RD;
                    end
                end
                else
                begin
                    cur_next   = par_q;
                    par_re     = 1'b1;
                    par_raddr  = par_q;
                    state_next = S_FOLD_FIND;
                end
            end
            S_FOLD_FIND:
            begin
                if (par_q == cur_reg)
                begin
                    root_next  = cur_reg;
                    sum_re     = 1'b1;
                    sum_raddr  = idx_reg;
                    state_next = S_FOLD_SI;
                end
                else
                begin
                    cur_next  = par_q;
                    par_re    = 1'b1;
                    par_raddr = par_q;
                end
            end
            S_FOLD_SI:
            begin
                isum_next  = sum_q;
                sum_re     = 1'b1;
                sum_raddr  = root_reg;
                state_next = S_FOLD_SR;
            end
            S_FOLD_SR:
            begin
                sum_we    = 1'b1;
                sum_waddr = root_reg;
                sum_wdata = fold_sums;
                if (idx_reg == count_reg)
                begin
                    idx_next   = LBL_W'(1);
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    idx_next   = LBL_W'(idx_reg + 1'b1);
                    state_next = S_FOLD_RD;
                end
            end
            S_EMIT_RD:
            begin
                par_re     = 1'b1;
                sum_re     = 1'b1;
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK:
            begin
                if (par_q == idx_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    idx_next   = LBL_W'(idx_reg + 1'b1);
                    state_next = S_EMIT_RD;
                end
            end
            S_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg == count_reg)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        idx_next   = LBL_W'(idx_reg + 1'b1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMPTY:
            begin
                out_star = 1'b0;
                out_last = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                left_next  = '0;
                prev_clr   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            last_root_reg <= '0;
            prev_vld_reg  <= '0;
            prev_vq_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            last_root_reg <= last_root_next;
            if (prev_re)
            begin
                prev_vq_reg <= prev_vld_reg[prev_raddr];
            end
            if (prev_clr)
            begin
                prev_vld_reg <= '0;
            end
            else if (prev_we)
            begin
                prev_vld_reg[prev_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        lab_reg  <= lab_next;
        cur_reg  <= cur_next;
        ra_reg   <= ra_next;
        nb_reg   <= nb_next;
        root_reg <= root_next;
        isum_reg <= isum_next;
        if (out_load)
        begin
            star_valid_reg     <= out_star;
            row_centroid_reg   <= out_star ? quot_row : '0;
            col_centroid_reg   <= out_star ? quot_col : '0;
            last_of_frame_reg  <= out_last;
            label_overflow_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re)
        begin
            prev_q <= prev_mem[prev_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (par_re)
        begin
            par_q <= par_mem[par_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re)
        begin
            sum_q <= sum_mem[sum_raddr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign star_valid     = star_valid_reg;
    assign row_centroid   = row_centroid_reg;
    assign col_centroid   = col_centroid_reg;
    assign last_of_frame  = last_of_frame_reg;
    assign label_overflow = label_overflow_reg;

endmodule
